// ===== sv/modbus_rtu_read_response_checker_assert.svh =====
// Assertion macros for the Modbus RTU response checker.
`ifndef MODBUS_RTU_READ_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_READ_RESPONSE_CHECKER_ASSERT_SVH

// Clocked check, masked while reset is held.
`define MRRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define MRRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== sv/mrrc_pkg.sv =====
// Shared types and constants for the Modbus RTU response checker.
package mrrc_pkg;

    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 16;
    localparam int POS_W      = 4;
    localparam int CFG_INDEX_W = 8;

    localparam logic [VALUE_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [VALUE_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE  = 8'd1;

    localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] FUNCTION_CODE_RESET  = 8'h03;

    // Fixed frame positions
    localparam logic [POS_W-1:0] POS_ADDRESS  = 4'd0;
    localparam logic [POS_W-1:0] POS_FUNCTION = 4'd1;
    localparam logic [POS_W-1:0] POS_VALUE_HI = 4'd3;
    localparam logic [POS_W-1:0] POS_VALUE_LO = 4'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_CRC_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] function_code;
    } mrrc_cfg_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] register_value;
    } mrrc_result_t;

endpackage

// ===== sv/modbus_rtu_read_response_checker.sv =====
// Modbus RTU read-one-register response checker: top level.
// Throughput: one byte per cycle; an input register and a result register
// sit either side of the combinational frame logic (unrolled CRC byte update).
// A pending result stalls the input only when the held byte also ends a frame.
// Reset: synchronous, active low; registers return to address 1, function 3.
module modbus_rtu_read_response_checker
    import mrrc_pkg::*;
#(
    parameter int FRAME_BYTES = 7
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    // Byte stream in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  logic [0:0]             s_tuser,   // [0] frame_start
    // Result stream out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [15:0] register_value
    output logic [1:0]             m_tuser    // [1:0] status
);

`include "modbus_rtu_read_response_checker_assert.svh"

    mrrc_cfg_t cfg_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    // Result register
    logic         out_valid_reg, out_valid_next;
    mrrc_result_t out_reg;

    logic         fire;
    logic         advance;
    mrrc_result_t result;

    // Config writes always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.function_code  <= FUNCTION_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                REG_FUNCTION_CODE:  cfg_reg.function_code  <= cfg_data;
                default: ;
            endcase
        end
    end

    mrrc_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .cfg         (cfg_reg),
        .fire        (fire),
        .result      (result)
    );

    // Held word moves on unless it ends a frame and the result slot is still full
    assign advance  = in_valid_reg && (!fire || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    assign out_valid_next = (advance && fire) || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.register_value;
    assign m_tuser  = out_reg.status;

    // A result never goes out with a reserved status code
    `MRRC_ASSERT(a_status_code, m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_MISMATCH || m_tuser == ST_CRC_ERR), "reserved status on result")
    // Only a good frame carries a register value
    `MRRC_ASSERT(a_value_zero, (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0), "value on failed frame")
    // A held input word that did not move stays put
    `MRRC_ASSERT(a_in_hold, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg) && $stable(in_start_reg)), "held word lost")
    // A new result is only loaded into a free or draining slot
    `MRRC_ASSERT_ALWAYS(a_no_overwrite, (aresetn && advance && fire && out_valid_reg) |-> m_tready, "result overwritten")

endmodule

// ===== sv/mrrc_crc_byte.sv =====
// CRC-16/MODBUS update over one byte, eight reflected steps unrolled.
module mrrc_crc_byte
    import mrrc_pkg::*;
(
    input  logic [VALUE_W-1:0] crc_in,
    input  logic [BYTE_W-1:0]  data_in,
    output logic [VALUE_W-1:0] crc_out
);

    always_comb begin
        logic [VALUE_W-1:0] acc;
        acc = crc_in ^ {{(VALUE_W-BYTE_W){1'b0}}, data_in};
        for (int i = 0; i < BYTE_W; i++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

// ===== sv/mrrc_frame.sv =====
// Frame tracker: position, header check, value capture and running CRC.
module mrrc_frame
    import mrrc_pkg::*;
#(
    parameter int FRAME_BYTES = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic               frame_start,
    input  mrrc_cfg_t          cfg,
    output logic               fire,
    output mrrc_result_t       result
);

    localparam logic [POS_W-1:0] LOW_POS  = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [VALUE_W-1:0] crc_reg, crc_next, crc_cur, crc_upd;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_cur;
    logic               hdr_ok_reg, hdr_ok_next, hdr_ok_cur;
    logic [VALUE_W-1:0] value_reg, value_next, value_cur;
    logic [BYTE_W-1:0]  crc_lo_reg, crc_lo_next, crc_lo_cur;
    logic               active_reg, active_next, active_cur;
    logic               last;
    logic [VALUE_W-1:0] rx_crc;

    // A start flag restarts the frame before the byte is looked at
    assign crc_cur    = frame_start ? CRC_INIT : crc_reg;
    assign pos_cur    = frame_start ? '0 : pos_reg;
    assign hdr_ok_cur = frame_start | hdr_ok_reg;
    assign value_cur  = frame_start ? '0 : value_reg;
    assign crc_lo_cur = frame_start ? '0 : crc_lo_reg;
    assign active_cur = frame_start | active_reg;

    mrrc_crc_byte u_crc (
        .crc_in  (crc_cur),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign last   = pos_cur >= LAST_POS;
    assign fire   = active_cur & last;
    assign rx_crc = {rx_byte, crc_lo_cur};

    always_comb begin
        hdr_ok_next = hdr_ok_cur;
        if ((pos_cur == POS_ADDRESS && rx_byte != cfg.device_address) ||
            (pos_cur == POS_FUNCTION && rx_byte != cfg.function_code)) begin
            hdr_ok_next = 1'b0;
        end

        value_next = value_cur;
        if (pos_cur == POS_VALUE_HI) begin
            value_next[VALUE_W-1:BYTE_W] = rx_byte;
        end
        if (pos_cur == POS_VALUE_LO) begin
            value_next[BYTE_W-1:0] = rx_byte;
        end

        crc_next    = crc_cur;
        crc_lo_next = crc_lo_cur;
        if (pos_cur < LOW_POS) begin
            crc_next = crc_upd;
        end else if (pos_cur == LOW_POS) begin
            crc_lo_next = rx_byte;
        end

        if (last) begin
            pos_next    = '0;
            active_next = 1'b0;
        end else begin
            pos_next    = pos_cur + 1'b1;
            active_next = active_cur;
        end

        // Mismatch wins over CRC error; value only with a good frame
        if (!hdr_ok_next) begin
            result.status         = ST_MISMATCH;
            result.register_value = '0;
        end else if (rx_crc != crc_cur) begin
            result.status         = ST_CRC_ERR;
            result.register_value = '0;
        end else begin
            result.status         = ST_OK;
            result.register_value = value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            value_reg  <= '0;
            crc_lo_reg <= '0;
            active_reg <= 1'b0;
        end else if (step && active_cur) begin
            crc_reg    <= crc_next;
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            value_reg  <= value_next;
            crc_lo_reg <= crc_lo_next;
            active_reg <= active_next;
        end
    end

endmodule
